>>> src/dqs_pkg.sv
// Shared constants, codes and types of the double-ended queue with running sum.
package dqs_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W   = ((2 * DATA_W + CNT_W + 7) / 8) * 8;

  localparam logic [DATA_W-1:0] EMPTY_MARK = DATA_W'(-999);

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic load;
    logic tail;
  } cell_ctl_t;

endpackage

>>> src/dqs_cell.sv
// One storage cell of the queue row, passing its entry to either neighbour.
module dqs_cell (
  input  logic                      clk_i,
  input  dqs_pkg::cell_ctl_t        ctl_i,
  input  logic [dqs_pkg::DATA_W-1:0] push_value_i,
  input  logic [dqs_pkg::DATA_W-1:0] lower_data_i,
  input  logic [dqs_pkg::DATA_W-1:0] upper_data_i,
  output logic [dqs_pkg::DATA_W-1:0] data_o,
  output logic [dqs_pkg::DATA_W-1:0] tail_data_o
);
  import dqs_pkg::*;

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    priority if (ctl_i.shift_up) begin
      data_d = lower_data_i;
    end else if (ctl_i.shift_down) begin
      data_d = upper_data_i;
    end else if (ctl_i.load) begin
      data_d = push_value_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o      = data_q;
  assign tail_data_o = ctl_i.tail ? data_q : '0;

endmodule

>>> src/double_ended_queue_with_sum_core.sv
// Top level of the double-ended queue with running sum, built as a row of cells.
// Each request pushes or pops one 32-bit value at either end of a queue held in a row of
// DEPTH cells, the front element always in the first cell; a push at the front or a pop at
// the front moves every cell's entry to its neighbour in the same cycle. One request is
// taken per clock cycle while not stalled; its result is registered, so a result appears
// in the cycle after its request; a new request is accepted only while the output register
// is empty or its result is taken in the same cycle, so a held result stalls the input.
// The result carries the popped value, a status, the element count and the wrapping sum.
module double_ended_queue_with_sum_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // push_value[31:0]
  input  logic [dqs_pkg::DATA_W-1:0] s_axis_tdata_i,
  // command[1:0]
  input  logic [1:0]                 s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // popped_value[31:0], element_count[38:32], element_sum[70:39], zero fill above
  output logic [dqs_pkg::OUT_W-1:0]  m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]                 m_axis_tuser_o
);
  import dqs_pkg::*;

  logic              accept;
  cmd_e              cmd;
  logic              is_push;
  logic              full;
  logic              empty;
  logic              do_op;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;
  logic [DATA_W-1:0] sum_q;
  logic [DATA_W-1:0] sum_d;
  logic [DATA_W-1:0] popped;
  logic [DATA_W-1:0] tail_value;
  status_e           status;
  logic              out_valid_q;
  logic              out_valid_d;
  logic [DATA_W-1:0] out_pop_q;
  logic [1:0]        out_status_q;
  logic [CNT_W-1:0]  out_count_q;
  logic [DATA_W-1:0] out_sum_q;

  cell_ctl_t         cell_ctl [DEPTH];
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_tail [DEPTH];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd             = cmd_e'(s_axis_tuser_i);
  assign is_push         = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK);
  assign full            = (count_q == CNT_W'(DEPTH));
  assign empty           = (count_q == '0);
  assign do_op           = accept && (is_push ? !full : !empty);

  always_comb begin
    tail_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_value = tail_value | cell_tail[i];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_comb begin
      cell_ctl[g].shift_up   = do_op && (cmd == CMD_PUSH_FRONT);
      cell_ctl[g].shift_down = do_op && (cmd == CMD_POP_FRONT);
      cell_ctl[g].load       = do_op && (cmd == CMD_PUSH_BACK) && (count_q == CNT_W'(g));
      cell_ctl[g].tail       = (count_q == CNT_W'(g + 1));
    end

    dqs_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (cell_ctl[g]),
      .push_value_i (s_axis_tdata_i),
      .lower_data_i ((g == 0) ? s_axis_tdata_i : cell_data[(g == 0) ? 0 : g - 1]),
      .upper_data_i ((g == DEPTH - 1) ? '0 : cell_data[(g == DEPTH - 1) ? g : g + 1]),
      .data_o       (cell_data[g]),
      .tail_data_o  (cell_tail[g])
    );
  end

  always_comb begin
    popped  = '0;
    status  = ST_OK;
    count_d = count_q;
    sum_d   = sum_q;
    unique case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
          sum_d   = sum_q + s_axis_tdata_i;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty) begin
          popped = EMPTY_MARK;
          status = ST_EMPTY;
        end else begin
          popped  = (cmd == CMD_POP_FRONT) ? cell_data[0] : tail_value;
          count_d = count_q - 1'b1;
          sum_d   = sum_q - popped;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign out_valid_d = accept || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
        sum_q   <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_pop_q    <= popped;
      out_status_q <= status;
      out_count_q  <= count_d;
      out_sum_q    <= sum_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({out_sum_q, out_count_q, out_pop_q});
  assign m_axis_tuser_o  = out_status_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("element count exceeds depth");

  a_ready_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  a_empty_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_push && empty |=> m_axis_tvalid_o && m_axis_tuser_o == ST_EMPTY
      && m_axis_tdata_o[DATA_W-1:0] == EMPTY_MARK)
    else $error("pop on empty queue not reported");

  a_count_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[DATA_W+CNT_W-1:DATA_W] == count_q)
    else $error("reported count differs from stored count");
`endif

endmodule
